### hdl/pps_pkg.sv
// shared types, constants and tables of the pure pursuit steering block
package pps_pkg;

    localparam int MAX_POINTS_DEF   = 1024;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SLOT_LIMIT       = 1024;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 24;

    localparam logic signed [33:0] INV_GAIN_Q28 = 34'sd163008218;
    localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOKAHEAD_BASE = 3'd0,
        CFG_WHEELBASE      = 3'd1,
        CFG_STEER_RATIO    = 3'd2,
        CFG_MAX_STEER      = 3'd3,
        CFG_PATH_COUNT     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] lookahead_base;
        logic [15:0] wheelbase;
        logic [15:0] steer_ratio;
        logic [14:0] max_steer;
        logic [10:0] path_count;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic [9:0]         point_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic [15:0]        speed;
    } t_in_beat;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN1, S_DRAIN1, S_SCAN2, S_DRAIN2, S_DECIDE, S_FWAIT,
        S_ROT, S_LAT, S_LATFIN, S_YM, S_CHK, S_NORM, S_VEC, S_MUL, S_SAT, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_NONE, PH_NEAR, PH_HIT, PH_TGT
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   capture;
        logic   issue;
        logic   scan_init2;
        logic   tgt_fix;
        logic   fetch;
        logic   rot_init;
        logic   rot_step;
        logic   lat_mul;
        logic   lat_fin;
        logic   ym_calc;
        logic   zero_z;
        logic   norm_step;
        logic   vec_init;
        logic   vec_step;
        logic   steer_mul;
        logic   steer_fin;
        logic   result_load;
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic scan_end;
        logic found;
        logic pipe_busy;
        logic stop;
        logic step_last;
        logic skip;
        logic norm_done;
        logic out_free;
    } t_status;

    // arctan(2^-i) in Q0.30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd7;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd0;
            5'd31: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/pps_if.sv
// valid/ready channel interfaces: input items, results, configuration writes
interface pps_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [9:0]         point_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic [15:0]        speed;
    modport source (output valid, mode, point_index, pos_x, pos_y, heading, speed,
                    input ready);
    modport sink   (input valid, mode, point_index, pos_x, pos_y, heading, speed,
                    output ready);
endinterface

interface pps_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] steer_angle;
    logic               stop;
    logic [9:0]         nearest_slot;
    logic [9:0]         target_slot;
    modport source (output valid, steer_angle, stop, nearest_slot, target_slot,
                    input ready);
    modport sink   (input valid, steer_angle, stop, nearest_slot, target_slot,
                    output ready);
endinterface

interface pps_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pps_pkg::CFG_IDX_W-1:0]    index;
    logic [pps_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pps_ram.sv
// generic single write port ram with registered read
module pps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/pps_datapath.sv
// datapath: path memory, distance pipeline, shared cordic, steering arithmetic
module pps_datapath #(
    parameter int MAX_POINTS   = pps_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pps_pkg::t_cfg      i_cfg,
    input  pps_pkg::t_in_beat  i_beat,
    input  pps_pkg::t_cmd      i_cmd,
    output pps_pkg::t_status   o_status,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [15:0] o_steer,
    output logic               o_stop,
    output logic [9:0]         o_nearest,
    output logic [9:0]         o_target
);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int SW    = $clog2(CORDIC_STEPS);
    localparam int LIMIT = (MAX_POINTS < pps_pkg::SLOT_LIMIT) ? MAX_POINTS
                                                              : pps_pkg::SLOT_LIMIT;

    logic [10:0] n_count;
    assign n_count = (i_cfg.path_count > 11'(LIMIT)) ? 11'(LIMIT) : i_cfg.path_count;

    // path memory
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   rd_x, rd_y;
    logic [10:0]   r_cnt, r_nearest, r_target;

    assign we    = i_cmd.load && ({7'd0, i_beat.point_index} < 17'(MAX_POINTS));
    assign waddr = AW'(i_beat.point_index);
    assign raddr = i_cmd.fetch ? AW'(r_target) : AW'(r_cnt);

    pps_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_beat.pos_x),
        .i_raddr(raddr), .o_rdata(rd_x)
    );
    pps_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_beat.pos_y),
        .i_raddr(raddr), .o_rdata(rd_y)
    );

    // pose registers
    logic signed [31:0] r_vx, r_vy;
    logic signed [15:0] r_head;
    logic [23:0]        r_look, look_n;
    logic [47:0]        r_look2;

    assign look_n = ({i_beat.speed, 8'd0} > i_cfg.lookahead_base)
                    ? {i_beat.speed, 8'd0} : i_cfg.lookahead_base;

    // distance pipeline
    logic               p1_v, p2_v, p3_v;
    logic [10:0]        p1_idx, p2_idx, p3_idx;
    logic signed [32:0] p2_dx, p2_dy, p3_dx, p3_dy;
    logic [63:0]        p3_sqx, p3_sqy;
    logic signed [65:0] sqx_full, sqy_full;
    logic [64:0]        sum, r_best, r_ld2, r_xl;
    logic signed [32:0] r_tdx, r_tdy;
    logic               r_first, r_found;

    assign sqx_full = p2_dx * p2_dx;
    assign sqy_full = p2_dy * p2_dy;
    assign sum      = {1'b0, p3_sqx} + {1'b0, p3_sqy};

    always_ff @(posedge i_clk) begin
        if (p1_v) begin
            p2_dx <= {rd_x[31], rd_x} - {r_vx[31], r_vx};
            p2_dy <= {rd_y[31], rd_y} - {r_vy[31], r_vy};
        end
        if (p2_v) begin
            p3_sqx <= sqx_full[63:0];
            p3_sqy <= sqy_full[63:0];
            p3_dx  <= p2_dx;
            p3_dy  <= p2_dy;
        end
        p1_idx <= r_cnt;
        p2_idx <= p1_idx;
        p3_idx <= p2_idx;
        if (i_cmd.capture) begin
            r_vx   <= i_beat.pos_x;
            r_vy   <= i_beat.pos_y;
            r_head <= i_beat.heading;
            r_look <= look_n;
        end
        r_look2 <= r_look * r_look;
        if (i_cmd.phase == pps_pkg::PH_NEAR && p3_v && (r_first || sum < r_best)) begin
            r_best <= sum;
        end
        if (i_cmd.phase == pps_pkg::PH_TGT && p3_v) begin
            r_ld2 <= sum;
            r_tdx <= p3_dx;
            r_tdy <= p3_dy;
        end
    end

    // scan control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            p1_v      <= 1'b0;
            p2_v      <= 1'b0;
            p3_v      <= 1'b0;
            r_first   <= 1'b0;
            r_found   <= 1'b0;
            r_cnt     <= '0;
            r_nearest <= '0;
            r_target  <= '0;
        end else begin
            p1_v <= i_cmd.issue | i_cmd.fetch;
            p2_v <= p1_v;
            p3_v <= p2_v;
            if (i_cmd.capture) begin
                r_cnt     <= '0;
                r_first   <= 1'b1;
                r_found   <= 1'b0;
                r_nearest <= '0;
                r_target  <= '0;
            end else if (i_cmd.scan_init2) begin
                r_cnt <= r_nearest + 11'd1;
            end else if (i_cmd.issue) begin
                r_cnt <= r_cnt + 11'd1;
            end
            unique case (i_cmd.phase)
                pps_pkg::PH_NEAR: begin
                    if (p3_v && (r_first || sum < r_best)) begin
                        r_nearest <= p3_idx;
                        r_first   <= 1'b0;
                    end
                end
                pps_pkg::PH_HIT: begin
                    if (p3_v && !r_found && sum >= {17'd0, r_look2}) begin
                        r_found  <= 1'b1;
                        r_target <= p3_idx;
                    end
                end
                pps_pkg::PH_TGT, pps_pkg::PH_NONE: ;
            endcase
            if (i_cmd.tgt_fix && !r_found) begin
                r_target <= n_count - 11'd1;
            end
        end
    end

    // shared cordic: rotation for sin/cos, vectoring for atan2
    logic signed [33:0] r_cx, r_cy, xs, ys, cs, sn;
    logic signed [35:0] r_cz, z0, z0_adj, atan_v;
    logic [SW-1:0]      r_step;
    logic               r_flip, flip_n, sel;

    assign z0     = {{3{r_head[15]}}, r_head, 17'd0};
    assign flip_n = (z0 > pps_pkg::HALF_PI_Q30) || (z0 < -pps_pkg::HALF_PI_Q30);
    assign z0_adj = (z0 > pps_pkg::HALF_PI_Q30) ? z0 - pps_pkg::PI_Q30
                  : (z0 < -pps_pkg::HALF_PI_Q30) ? z0 + pps_pkg::PI_Q30 : z0;
    assign xs     = r_cx >>> r_step;
    assign ys     = r_cy >>> r_step;
    assign atan_v = {6'd0, pps_pkg::atan_q30(5'(r_step))};
    assign sel    = i_cmd.rot_step ? !r_cz[35] : r_cy[33];
    assign cs     = r_flip ? -r_cx : r_cx;
    assign sn     = r_flip ? -r_cy : r_cy;

    // steering arithmetic
    logic signed [66:0] r_pa, r_pb;
    logic signed [67:0] lat_diff;
    logic signed [39:0] r_lat;
    logic [39:0]        lat_mag;
    logic [55:0]        ym_prod;
    logic [63:0]        r_ym;
    logic signed [52:0] r_sp, sp_rnd;
    logic signed [27:0] st_raw;
    logic signed [27:0] max_s;
    logic signed [15:0] r_steer;

    assign lat_diff = {r_pa[66], r_pa} - {r_pb[66], r_pb};
    assign lat_mag  = r_lat[39] ? 40'(-r_lat) : 40'(r_lat);
    assign ym_prod  = lat_mag * i_cfg.wheelbase;
    assign sp_rnd   = r_sp + 53'sd16777216;
    assign st_raw   = sp_rnd[52:25];
    assign max_s    = {13'd0, i_cfg.max_steer};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot_init) begin
            r_cx   <= pps_pkg::INV_GAIN_Q28;
            r_cy   <= '0;
            r_cz   <= z0_adj;
            r_flip <= flip_n;
            r_step <= '0;
        end else if (i_cmd.vec_init) begin
            r_cx   <= {4'd0, r_xl[29:0]};
            r_cy   <= r_lat[39] ? -{4'd0, r_ym[29:0]} : {4'd0, r_ym[29:0]};
            r_cz   <= '0;
            r_step <= '0;
        end else if (i_cmd.rot_step || i_cmd.vec_step) begin
            if (sel) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - atan_v;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + atan_v;
            end
            r_step <= r_step + SW'(1);
        end else if (i_cmd.zero_z) begin
            r_cz <= '0;
        end
        if (i_cmd.lat_mul) begin
            r_pa <= r_tdy * cs;
            r_pb <= r_tdx * sn;
        end
        if (i_cmd.lat_fin) begin
            r_lat <= lat_diff[67:28];
        end
        if (i_cmd.ym_calc) begin
            r_ym <= {ym_prod[54:0], 9'd0};
            r_xl <= r_ld2;
        end else if (i_cmd.norm_step) begin
            r_ym <= r_ym >> 1;
            r_xl <= r_xl >> 1;
        end
        if (i_cmd.steer_mul) begin
            r_sp <= r_cz * $signed({1'b0, i_cfg.steer_ratio});
        end
        if (i_cmd.steer_fin) begin
            if (st_raw > max_s) begin
                r_steer <= 16'(max_s);
            end else if (st_raw < -max_s) begin
                r_steer <= 16'(-max_s);
            end else begin
                r_steer <= st_raw[15:0];
            end
        end
    end

    // result register
    logic stop_w;
    assign stop_w = (n_count == 11'd0) || (r_target == n_count - 11'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            o_steer   <= stop_w ? 16'sd0 : r_steer;
            o_stop    <= stop_w;
            o_nearest <= r_nearest[9:0];
            o_target  <= r_target[9:0];
        end
    end

    always_comb begin
        o_status.n_zero    = (n_count == 11'd0);
        o_status.scan_end  = (r_cnt >= n_count);
        o_status.found     = r_found;
        o_status.pipe_busy = p1_v | p2_v | p3_v;
        o_status.stop      = stop_w;
        o_status.step_last = (r_step == SW'(CORDIC_STEPS - 1));
        o_status.skip      = (r_ym == 64'd0) || (r_xl == 65'd0);
        o_status.norm_done = (r_xl[64:30] == '0) && (r_ym[63:30] == '0);
        o_status.out_free  = !o_out_valid || i_out_ready;
    end
endmodule

### hdl/pps_ctrl.sv
// controller: sequences scans, cordic passes and result delivery
module pps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    output logic             o_in_ready,
    input  pps_pkg::t_status i_status,
    output pps_pkg::t_cmd    o_cmd
);
    pps_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pps_pkg::S_IDLE: begin
                if (i_in_valid && i_in_mode) begin
                    n_state = i_status.n_zero ? pps_pkg::S_OUT : pps_pkg::S_SCAN1;
                end
            end
            pps_pkg::S_SCAN1:  if (i_status.scan_end) n_state = pps_pkg::S_DRAIN1;
            pps_pkg::S_DRAIN1: if (!i_status.pipe_busy) n_state = pps_pkg::S_SCAN2;
            pps_pkg::S_SCAN2: begin
                if (i_status.scan_end || i_status.found) n_state = pps_pkg::S_DRAIN2;
            end
            pps_pkg::S_DRAIN2: if (!i_status.pipe_busy) n_state = pps_pkg::S_DECIDE;
            pps_pkg::S_DECIDE: n_state = i_status.stop ? pps_pkg::S_OUT : pps_pkg::S_FWAIT;
            pps_pkg::S_FWAIT:  if (!i_status.pipe_busy) n_state = pps_pkg::S_ROT;
            pps_pkg::S_ROT:    if (i_status.step_last) n_state = pps_pkg::S_LAT;
            pps_pkg::S_LAT:    n_state = pps_pkg::S_LATFIN;
            pps_pkg::S_LATFIN: n_state = pps_pkg::S_YM;
            pps_pkg::S_YM:     n_state = pps_pkg::S_CHK;
            pps_pkg::S_CHK:    n_state = i_status.skip ? pps_pkg::S_MUL : pps_pkg::S_NORM;
            pps_pkg::S_NORM:   if (i_status.norm_done) n_state = pps_pkg::S_VEC;
            pps_pkg::S_VEC:    if (i_status.step_last) n_state = pps_pkg::S_MUL;
            pps_pkg::S_MUL:    n_state = pps_pkg::S_SAT;
            pps_pkg::S_SAT:    n_state = pps_pkg::S_OUT;
            pps_pkg::S_OUT:    if (i_status.out_free) n_state = pps_pkg::S_IDLE;
            default:           n_state = pps_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pps_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid && i_in_mode;
                o_cmd.load    = i_in_valid && !i_in_mode;
            end
            pps_pkg::S_SCAN1: begin
                o_cmd.phase = pps_pkg::PH_NEAR;
                o_cmd.issue = !i_status.scan_end;
            end
            pps_pkg::S_DRAIN1: begin
                o_cmd.phase      = pps_pkg::PH_NEAR;
                o_cmd.scan_init2 = !i_status.pipe_busy;
            end
            pps_pkg::S_SCAN2: begin
                o_cmd.phase = pps_pkg::PH_HIT;
                o_cmd.issue = !i_status.scan_end && !i_status.found;
            end
            pps_pkg::S_DRAIN2: begin
                o_cmd.phase   = pps_pkg::PH_HIT;
                o_cmd.tgt_fix = !i_status.pipe_busy;
            end
            pps_pkg::S_DECIDE: o_cmd.fetch = !i_status.stop;
            pps_pkg::S_FWAIT: begin
                o_cmd.phase    = pps_pkg::PH_TGT;
                o_cmd.rot_init = !i_status.pipe_busy;
            end
            pps_pkg::S_ROT:    o_cmd.rot_step = 1'b1;
            pps_pkg::S_LAT:    o_cmd.lat_mul  = 1'b1;
            pps_pkg::S_LATFIN: o_cmd.lat_fin  = 1'b1;
            pps_pkg::S_YM:     o_cmd.ym_calc  = 1'b1;
            pps_pkg::S_CHK:    o_cmd.zero_z   = i_status.skip;
            pps_pkg::S_NORM: begin
                o_cmd.norm_step = !i_status.norm_done;
                o_cmd.vec_init  = i_status.norm_done;
            end
            pps_pkg::S_VEC:    o_cmd.vec_step    = 1'b1;
            pps_pkg::S_MUL:    o_cmd.steer_mul   = 1'b1;
            pps_pkg::S_SAT:    o_cmd.steer_fin   = 1'b1;
            pps_pkg::S_OUT:    o_cmd.result_load = i_status.out_free;
            default: ;
        endcase
    end
endmodule

### hdl/pure_pursuit_steering.sv
// top level of the pure pursuit steering block
//
//  channel   direction  payload                                       accepted when
//  i_in      sink       mode, point_index, pos_x, pos_y, heading,     valid & ready
//                       speed
//  o_out     source     steer_angle, stop, nearest_slot, target_slot  valid & ready
//  i_cfg     sink       index, data                                   valid & ready
//
//  a load beat writes the point into the x and y path memories if point_index is
//  below MAX_POINTS; for a pose the nearest and the lookahead point are each found
//  by a scan through the read port, one point per cycle; unless the target is the
//  last point, the cordic unit runs CORDIC_STEPS rotation steps and, if no vector
//  part is zero, up to 35 normalizing shifts and CORDIC_STEPS vectoring steps
//  reset is synchronous and active low; the path memories are not cleared
//  a result waits in the output register while the next beat is taken; a pose
//  finishing while the register is still full holds until it drains
module pure_pursuit_steering #(
    parameter int MAX_POINTS   = pps_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pps_in_if.sink    i_in,
    pps_out_if.source o_out,
    pps_cfg_if.sink   i_cfg
);
    pps_pkg::t_cfg     r_cfg;
    pps_pkg::t_in_beat beat;
    pps_pkg::t_cmd     cmd;
    pps_pkg::t_status  status;

    // configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lookahead_base <= 24'd65536;
            r_cfg.wheelbase      <= 16'd256;
            r_cfg.steer_ratio    <= 16'd256;
            r_cfg.max_steer      <= 15'd4290;
            r_cfg.path_count     <= 11'd0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pps_pkg::CFG_LOOKAHEAD_BASE: r_cfg.lookahead_base <= i_cfg.data[23:0];
                pps_pkg::CFG_WHEELBASE:      r_cfg.wheelbase      <= i_cfg.data[15:0];
                pps_pkg::CFG_STEER_RATIO:    r_cfg.steer_ratio    <= i_cfg.data[15:0];
                pps_pkg::CFG_MAX_STEER:      r_cfg.max_steer      <= i_cfg.data[14:0];
                pps_pkg::CFG_PATH_COUNT:     r_cfg.path_count     <= i_cfg.data[10:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // input beat gathered into one word for the datapath
    always_comb begin
        beat.mode        = i_in.mode;
        beat.point_index = i_in.point_index;
        beat.pos_x       = i_in.pos_x;
        beat.pos_y       = i_in.pos_y;
        beat.heading     = i_in.heading;
        beat.speed       = i_in.speed;
    end

    // sequencer
    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // memories, distance pipeline, cordic and output register
    pps_datapath #(
        .MAX_POINTS   (MAX_POINTS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_beat      (beat),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_steer     (o_out.steer_angle),
        .o_stop      (o_out.stop),
        .o_nearest   (o_out.nearest_slot),
        .o_target    (o_out.target_slot)
    );
endmodule

### hdl/pps_checker.sv
// port level checks of the steering block, bound to the top level
module pps_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_mode,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [15:0] steer,
    input logic              stop,
    input logic [9:0]        nearest,
    input logic [9:0]        target
);
    logic [1:0] r_pend;
    logic       pose_fire, out_fire;

    assign pose_fire = in_valid && in_ready && in_mode;
    assign out_fire  = out_valid && out_ready;

    // poses taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + {1'b0, pose_fire} - {1'b0, out_fire};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(steer) && $stable(stop)
            && $stable(nearest) && $stable(target))
        else $error("result beat changed while stalled");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |-> r_pend != 2'd0)
        else $error("result beat without a pose");

    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many poses in flight");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && stop |-> steer == 16'sd0)
        else $error("stop result with nonzero steering");

    a_target_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !stop |-> target > nearest)
        else $error("lookahead slot not after nearest slot");
endmodule

bind pure_pursuit_steering pps_checker u_pps_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_mode   (i_in.mode),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .steer     (o_out.steer_angle),
    .stop      (o_out.stop),
    .nearest   (o_out.nearest_slot),
    .target    (o_out.target_slot)
);
